FILE: src/mbrp_pkg.sv
// Shared types and constants of the multibulk request parser.
// Holds the result kinds, the result record and sizing defaults; no dependencies.
`default_nettype none

package mbrp_pkg;

  localparam int unsigned MAX_ARG_LEN = 1048576;
  localparam int unsigned OUT_DEPTH   = 3;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
    logic [6:0] arg_index;
    logic       arg_end;
  } result_t;

endpackage

`default_nettype wire

FILE: src/mbrp_parser.sv
// Frame parser of the multibulk request parser: phase, number and argument tracking.
// Consumes one registered byte per cycle while step_i is high and yields at most one result; uses mbrp_pkg.
`default_nettype none

module mbrp_parser #(
  parameter int unsigned MaxArgLen = mbrp_pkg::MAX_ARG_LEN
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire logic [7:0]      rx_byte_i,
  output logic                 res_valid_o,
  output mbrp_pkg::result_t    res_o
);

  localparam int unsigned LenW = $clog2(MaxArgLen + 1);
  localparam int unsigned NumW = (LenW > 7) ? LenW : 7;
  localparam int unsigned ProdW = NumW + 4;

  localparam logic [3:0] PhStar    = 4'd0;
  localparam logic [3:0] PhCntDig  = 4'd1;
  localparam logic [3:0] PhCntLf   = 4'd2;
  localparam logic [3:0] PhDollar  = 4'd3;
  localparam logic [3:0] PhLenDig  = 4'd4;
  localparam logic [3:0] PhLenLf   = 4'd5;
  localparam logic [3:0] PhPayload = 4'd6;
  localparam logic [3:0] PhPayCr   = 4'd7;
  localparam logic [3:0] PhPayLf   = 4'd8;
  localparam logic [3:0] PhDead    = 4'd9;

  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;

  localparam logic [ProdW-1:0] CountMax = ProdW'(99);
  localparam logic [ProdW-1:0] LenMax   = ProdW'(MaxArgLen);

  logic [3:0]      phase_q, phase_d;
  logic [NumW-1:0] acc_q, acc_d;
  logic [6:0]      args_exp_q, args_exp_d;
  logic [6:0]      args_done_q, args_done_d;
  logic [LenW-1:0] left_q, left_d;

  logic             digit;
  logic [ProdW-1:0] acc_ext;
  logic [ProdW-1:0] acc_next;
  logic [ProdW-1:0] limit;
  logic             last;
  logic [6:0]       done_inc;

  assign digit    = rx_byte_i inside {[ChZero:ChNine]};
  assign acc_ext  = {4'b0, acc_q};
  assign acc_next = (acc_ext << 3) + (acc_ext << 1) + {{NumW{1'b0}}, rx_byte_i[3:0]};
  assign limit    = (phase_q == PhCntDig) ? CountMax : LenMax;
  assign last     = (left_q <= LenW'(1));
  assign done_inc = args_done_q + 7'd1;

  always_comb begin
    phase_d     = phase_q;
    acc_d       = acc_q;
    args_exp_d  = args_exp_q;
    args_done_d = args_done_q;
    left_d      = left_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (step_i) begin
      case (phase_q)
        PhStar: begin
          if (rx_byte_i != ChStar) begin
            phase_d = PhDead;
          end else begin
            acc_d   = '0;
            phase_d = PhCntDig;
          end
        end
        PhCntDig, PhLenDig: begin
          if (rx_byte_i == ChCr) begin
            phase_d = (phase_q == PhCntDig) ? PhCntLf : PhLenLf;
          end else if (!digit || (acc_next > limit)) begin
            phase_d = PhDead;
          end else begin
            acc_d = acc_next[NumW-1:0];
          end
        end
        PhCntLf: begin
          if ((rx_byte_i != ChLf) || (acc_q == '0)) begin
            phase_d = PhDead;
          end else begin
            args_exp_d  = acc_q[6:0];
            args_done_d = '0;
            phase_d     = PhDollar;
          end
        end
        PhDollar: begin
          if (rx_byte_i != ChDollar) begin
            phase_d = PhDead;
          end else begin
            acc_d   = '0;
            phase_d = PhLenDig;
          end
        end
        PhLenLf: begin
          if ((rx_byte_i != ChLf) || (acc_q == '0)) begin
            phase_d = PhDead;
          end else begin
            left_d  = acc_q[LenW-1:0];
            phase_d = PhPayload;
          end
        end
        PhPayload: begin
          res_valid_o     = 1'b1;
          res_o.kind      = mbrp_pkg::KIND_DATA;
          res_o.data_byte = rx_byte_i;
          res_o.arg_index = args_done_q;
          res_o.arg_end   = last;
          left_d          = last ? '0 : left_q - LenW'(1);
          if (last) begin
            phase_d = PhPayCr;
          end
        end
        PhPayCr: begin
          phase_d = (rx_byte_i != ChCr) ? PhDead : PhPayLf;
        end
        PhPayLf: begin
          if (rx_byte_i != ChLf) begin
            phase_d = PhDead;
          end else if (done_inc >= args_exp_q) begin
            args_done_d = '0;
            args_exp_d  = '0;
            acc_d       = '0;
            phase_d     = PhStar;
            res_valid_o = 1'b1;
            res_o.kind  = mbrp_pkg::KIND_DONE;
          end else begin
            args_done_d = done_inc;
            phase_d     = PhDollar;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
      if ((phase_d == PhDead) && (phase_q != PhDead) &&
          (phase_q <= PhPayLf)) begin
        res_valid_o = 1'b1;
        res_o       = '0;
        res_o.kind  = mbrp_pkg::KIND_ERROR;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhStar;
      acc_q       <= '0;
      args_exp_q  <= '0;
      args_done_q <= '0;
      left_q      <= '0;
    end else begin
      phase_q     <= phase_d;
      acc_q       <= acc_d;
      args_exp_q  <= args_exp_d;
      args_done_q <= args_done_d;
      left_q      <= left_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/mbrp_out_fifo.sv
// Result queue of the multibulk request parser, holding finished results for the receiver.
// Small register queue with a fill count; uses mbrp_pkg.
`default_nettype none

module mbrp_out_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire mbrp_pkg::result_t push_data_i,
  input  wire logic              pop_i,
  output mbrp_pkg::result_t      head_o,
  output logic [$clog2(mbrp_pkg::OUT_DEPTH+1)-1:0] count_o
);

  localparam int unsigned Depth = mbrp_pkg::OUT_DEPTH;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  mbrp_pkg::result_t entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o  = entry_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

`default_nettype wire

FILE: src/multibulk_request_parser_unit.sv
// Multibulk request parser top level: input byte register, frame parser, result queue.
// Instantiates mbrp_parser and mbrp_out_fifo; uses mbrp_pkg.
//
// Usage:
//   Input channel (in_valid_i, in_stall_o, rx_byte_i) takes one request byte per
//   transfer. Output channel (out_valid_o, out_stall_i, kind_o, data_byte_o,
//   arg_index_o, arg_end_o) gives zero or one result per byte: a payload byte with
//   its argument index and last-byte mark, a command-complete, or a format error.
//   After an error every further byte is taken and dropped until reset.
//   A result passes the input byte register and then the result queue before it is
//   shown. Throughput: one byte per cycle while in_stall_o is low, set by the single
//   parse stage between the input byte register and a three-entry result queue.
//   in_stall_o rises when the queue plus the input register hold three items, so
//   a stalled receiver backs up the input after at most three results.
//   A stalled result holds its fields until taken.
//   Reset clears the valid flag of the input register, the queue and the parser,
//   which then waits for a star byte.
`default_nettype none

module multibulk_request_parser_unit #(
  parameter int unsigned MaxArgLen = mbrp_pkg::MAX_ARG_LEN
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      data_byte_o,
  output logic [6:0]      arg_index_o,
  output logic            arg_end_o
);

  localparam int unsigned CntW = $clog2(mbrp_pkg::OUT_DEPTH + 1);

  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              in_xfer;
  logic              res_valid;
  mbrp_pkg::result_t res;
  mbrp_pkg::result_t head;
  logic [CntW-1:0]   count;
  logic              out_pop;
  logic [CntW:0]     in_flight;

  assign in_flight  = {1'b0, count} + (CntW + 1)'(in_valid_q);
  assign in_stall_o = (in_flight >= (CntW + 1)'(mbrp_pkg::OUT_DEPTH));
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_byte_q <= rx_byte_i;
    end
  end

  mbrp_parser #(
    .MaxArgLen (MaxArgLen)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_valid_q),
    .rx_byte_i   (in_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_pop = out_valid_o && !out_stall_i;

  mbrp_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .pop_i       (out_pop),
    .head_o      (head),
    .count_o     (count)
  );

  assign out_valid_o = (count != '0);
  assign kind_o      = head.kind;
  assign data_byte_o = head.data_byte;
  assign arg_index_o = head.arg_index;
  assign arg_end_o   = head.arg_end;

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (count < CntW'(mbrp_pkg::OUT_DEPTH)))
    else $error("result pushed into a full queue");

  a_silent_after_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && (res.kind == mbrp_pkg::KIND_ERROR)) |=> !res_valid)
    else $error("result produced after a format error");

  a_non_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && (res.kind != mbrp_pkg::KIND_DATA)) |->
      ((res.data_byte == 8'd0) && (res.arg_index == 7'd0) && !res.arg_end))
    else $error("non-payload result carries payload fields");

  a_result_needs_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> in_valid_q)
    else $error("result produced without an input byte");
`endif

endmodule

`default_nettype wire
